// ----- hdl/binary_to_decimal_ascii_macros.svh -----
// Assertion macros for the converter RTL.
`ifndef BINARY_TO_DECIMAL_ASCII_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_MACROS_SVH

`ifndef NO_ASSERTIONS

`define B2DA_ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("converter assertion failed");

`define B2DA_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("converter assertion failed");

`define B2DA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("converter assertion failed");

`else

`define B2DA_ASSERT_ALWAYS(label, expr)
`define B2DA_ASSERT_IMPLIES(label, ante, cons)
`define B2DA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- hdl/b2da_pkg.sv -----
`default_nettype none

package b2da_pkg;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_CLEAR,
		CELL_DABBLE,
		CELL_RISE
	} cell_mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONVERT,
		ST_OUT
	} state_t;

	typedef struct packed {
		cell_mode_t mode;
		logic       ser_bit;
	} cell_ctrl_t;

	localparam logic [5:0] ASCII_ZERO = 6'd48;
	localparam logic [3:0] BCD_LIMIT  = 4'd5;
	localparam logic [3:0] BCD_ADJUST = 4'd3;

endpackage

`default_nettype wire

// ----- hdl/b2da_cell.sv -----
`default_nettype none

module b2da_cell (
	input  wire logic                  clk,
	input  wire b2da_pkg::cell_mode_t  mode,
	input  wire logic                  bit_in,
	input  wire logic [3:0]            digit_in,
	output logic                       bit_out,
	output logic [3:0]                 digit
);

	logic [3:0] digit_q;
	logic [3:0] adj;

	// Add three before the shift so that a digit of five or more carries into the next cell.
	always_comb begin
		adj = (digit_q >= b2da_pkg::BCD_LIMIT) ? digit_q + b2da_pkg::BCD_ADJUST : digit_q;
	end

	assign bit_out = adj[3];
	assign digit   = digit_q;

	always_ff @(posedge clk) begin
		case (mode)
			b2da_pkg::CELL_CLEAR:  digit_q <= 4'd0;
			b2da_pkg::CELL_DABBLE: digit_q <= {adj[2:0], bit_in};
			b2da_pkg::CELL_RISE:   digit_q <= digit_in;
			default:               digit_q <= digit_q;
		endcase
	end

endmodule

`default_nettype wire

// ----- hdl/b2da_ctrl.sv -----
`default_nettype none

module b2da_ctrl #(
	parameter int VALUE_BITS = 64,
	parameter int NUM_DIGITS = 20
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic [VALUE_BITS-1:0]   value_bits,
	input  wire logic [3:0]              top_digit,
	output logic                         busy,
	output logic                         strobe,
	output logic                         last,
	output b2da_pkg::cell_ctrl_t         ctrl
);

	localparam int CW = $clog2(VALUE_BITS);

	b2da_pkg::state_t        state_q, state_d;
	logic [CW-1:0]           cnt_q;
	logic                    seen_q;
	logic [VALUE_BITS-1:0]   shreg_q;
	logic                    cnt_zero;

	assign cnt_zero = (cnt_q == '0);

	always_comb begin
		state_d = state_q;
		case (state_q)
			b2da_pkg::ST_IDLE: begin
				if (start) state_d = b2da_pkg::ST_CONVERT;
			end
			b2da_pkg::ST_CONVERT: begin
				if (cnt_zero) state_d = b2da_pkg::ST_OUT;
			end
			b2da_pkg::ST_OUT: begin
				if (cnt_zero) state_d = b2da_pkg::ST_IDLE;
			end
			default: state_d = b2da_pkg::ST_IDLE;
		endcase
	end

	// Leading zeros rise out of the top cell without a strobe; the lowest digit is always shown.
	always_comb begin
		busy         = 1'b1;
		strobe       = 1'b0;
		ctrl.mode    = b2da_pkg::CELL_HOLD;
		ctrl.ser_bit = shreg_q[VALUE_BITS-1];
		case (state_q)
			b2da_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) ctrl.mode = b2da_pkg::CELL_CLEAR;
			end
			b2da_pkg::ST_CONVERT: begin
				ctrl.mode = b2da_pkg::CELL_DABBLE;
			end
			b2da_pkg::ST_OUT: begin
				ctrl.mode = b2da_pkg::CELL_RISE;
				strobe    = (top_digit != 4'd0) || seen_q || cnt_zero;
			end
			default: busy = 1'b0;
		endcase
		last = strobe && cnt_zero;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= b2da_pkg::ST_IDLE;
			cnt_q   <= '0;
			seen_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				b2da_pkg::ST_IDLE: begin
					if (start) begin
						cnt_q  <= CW'(VALUE_BITS - 1);
						seen_q <= 1'b0;
					end
				end
				b2da_pkg::ST_CONVERT: begin
					cnt_q <= cnt_zero ? CW'(NUM_DIGITS - 1) : cnt_q - CW'(1);
				end
				b2da_pkg::ST_OUT: begin
					if (!cnt_zero) cnt_q <= cnt_q - CW'(1);
					seen_q <= seen_q || strobe;
				end
				default: cnt_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == b2da_pkg::ST_IDLE && start) begin
			shreg_q <= value_bits;
		end else if (state_q == b2da_pkg::ST_CONVERT) begin
			shreg_q <= shreg_q << 1;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/binary_to_decimal_ascii.sv -----
`default_nettype none
`include "binary_to_decimal_ascii_macros.svh"

// Converts an unsigned number (the low VALUE_BITS bits of value) to decimal ASCII
// text, most significant digit first, without leading zeros. A transaction is taken
// when start is high and busy is low; busy then stays high through the conversion and
// the output of the digits, with one digit cell per decimal digit (20 cells for 64 bits).
// The conversion shifts the number one bit a cycle into a row of BCD cells; the output
// phase then moves one digit a cycle out of the top cell. Each character appears for one
// cycle with strobe high and cannot be held off by the receiver; leading zeros leave
// gaps without strobe before the first character, and last marks the final one.
module binary_to_decimal_ascii #(
	parameter int VALUE_BITS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] value,
	output logic             busy,
	output logic             strobe,
	output logic [5:0]       digit_char,
	output logic             last
);

	// Decimal digits of 2^VALUE_BITS - 1: floor(VALUE_BITS * log10(2)) + 1.
	localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;

	b2da_pkg::cell_ctrl_t ctrl;
	logic [NUM_DIGITS-1:0] carry;
	logic [3:0]            digit [NUM_DIGITS];

	b2da_ctrl #(
		.VALUE_BITS (VALUE_BITS),
		.NUM_DIGITS (NUM_DIGITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.value_bits (value[VALUE_BITS-1:0]),
		.top_digit  (digit[NUM_DIGITS-1]),
		.busy       (busy),
		.strobe     (strobe),
		.last       (last),
		.ctrl       (ctrl)
	);

	for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
		logic       bit_in;
		logic [3:0] digit_in;
		if (i == 0) begin : g_low
			assign bit_in   = ctrl.ser_bit;
			assign digit_in = 4'd0;
		end else begin : g_up
			assign bit_in   = carry[i-1];
			assign digit_in = digit[i-1];
		end
		b2da_cell u_cell (
			.clk      (clk),
			.mode     (ctrl.mode),
			.bit_in   (bit_in),
			.digit_in (digit_in),
			.bit_out  (carry[i]),
			.digit    (digit[i])
		);
	end

	assign digit_char = b2da_pkg::ASCII_ZERO + {2'b00, digit[NUM_DIGITS-1]};

	// The row of cells is sized so that nothing ever carries out of the top cell.
	`B2DA_ASSERT_IMPLIES(a_no_overflow, ctrl.mode == b2da_pkg::CELL_DABBLE, !carry[NUM_DIGITS-1])
	`B2DA_ASSERT_IMPLIES(a_strobe_busy, strobe, busy)
	`B2DA_ASSERT_NEXT(a_last_ends, strobe && last, !busy)
	`B2DA_ASSERT_NEXT(a_start_busy, start && !busy, busy && !strobe)

endmodule

`default_nettype wire

// ----- tb/decimal_text_checker.sv -----
`timescale 1ns / 100ps

module decimal_text_checker #(
	parameter int VALUE_BITS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic [63:0] value,
	input  wire logic        strobe,
	input  wire logic [5:0]  digit_char,
	input  wire logic        last,
	output int               mismatches,
	output int               outstanding,
	output int               values_taken,
	output int               chars_checked,
	output int               shortest_run,
	output int               longest_run
);

	localparam logic [63:0] DECIMAL_BASE = 64'd10;
	localparam int          MAX_DIGITS   = 20;
	localparam int          MAX_PRINTED  = 20;

	typedef struct packed {
		logic [5:0] ch;
		logic       fin;
	} text_char_t;

	text_char_t expected_chars[$];
	int         run_len;

	initial begin
		mismatches    = 0;
		outstanding   = 0;
		values_taken  = 0;
		chars_checked = 0;
		shortest_run  = MAX_DIGITS;
		longest_run   = 0;
		run_len       = 0;
	end

	task automatic report_mismatch(input string what);
		if (mismatches < MAX_PRINTED)
			$display("%0t ns: mismatch: %s", $time, what);
		mismatches++;
	endtask

	// Splits the number into decimal digits and queues them most significant first.
	function automatic void queue_decimal_text(input logic [63:0] raw);
		logic [63:0] num;
		logic [3:0]  digs[MAX_DIGITS];
		text_char_t  item;
		int          n;
		int          k;
		num = (VALUE_BITS >= 64) ? raw : (raw & ((64'd1 << VALUE_BITS) - 64'd1));
		n   = 0;
		do begin
			digs[n] = 4'(num % DECIMAL_BASE);
			num     = num / DECIMAL_BASE;
			n++;
		end while (num != 64'd0 && n < MAX_DIGITS);
		for (k = 0; k < n; k++) begin
			item.ch  = b2da_pkg::ASCII_ZERO + 6'(digs[n - 1 - k]);
			item.fin = (k == n - 1);
			expected_chars.push_back(item);
		end
	endfunction

	always @(posedge clk) begin
		text_char_t want;
		if (arst_n) begin
			if (strobe) begin
				chars_checked++;
				run_len++;
				if (expected_chars.size() == 0) begin
					report_mismatch($sformatf("character %0d with nothing expected", digit_char));
				end else begin
					want = expected_chars.pop_front();
					if (digit_char !== want.ch)
						report_mismatch($sformatf("digit_char %0d, expected %0d",
							digit_char, want.ch));
					if (last !== want.fin)
						report_mismatch($sformatf("last %b, expected %b", last, want.fin));
				end
				if (last === 1'b1) begin
					if (run_len < shortest_run) shortest_run = run_len;
					if (run_len > longest_run) longest_run = run_len;
					run_len = 0;
				end
			end
			// A new transaction only starts while busy is low.
			if (start && !busy) begin
				values_taken++;
				queue_decimal_text(value);
			end
			outstanding = expected_chars.size();
		end
	end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

	localparam int RANDOM_ITEMS   = 300;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int END_WAIT       = 100;
	localparam int IDLE_PERCENT   = 32;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic [63:0] value;
	logic        busy;
	logic        strobe;
	logic [5:0]  digit_char;
	logic        last;

	int mismatches;
	int outstanding;
	int values_taken;
	int chars_checked;
	int shortest_run;
	int longest_run;
	int quiet_cycles;
	int directed_count;

	binary_to_decimal_ascii u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.value      (value),
		.busy       (busy),
		.strobe     (strobe),
		.digit_char (digit_char),
		.last       (last)
	);

	decimal_text_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.value         (value),
		.strobe        (strobe),
		.digit_char    (digit_char),
		.last          (last),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.values_taken  (values_taken),
		.chars_checked (chars_checked),
		.shortest_run  (shortest_run),
		.longest_run   (longest_run)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Any quiet stretch longer than a conversion plus the longest sender gap means a hang.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog expired with %0d characters still expected.", outstanding);
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Called at a falling edge; returns at the falling edge after the value is accepted.
	task automatic send_value(input logic [63:0] num, input bit may_idle);
		int gap;
		if (may_idle && $urandom_range(99) < IDLE_PERCENT) begin
			gap   = ($urandom_range(3) == 0) ? $urandom_range(1, 120) : $urandom_range(1, 4);
			start = 1'b0;
			value = {$urandom, $urandom};
			repeat (gap) @(negedge clk);
		end
		start = 1'b1;
		value = num;
		// Busy only changes at a rising edge, so low here means the next edge accepts.
		while (busy) @(negedge clk);
		@(negedge clk);
	endtask

	initial begin
		logic [63:0] directed_values[] = '{
			64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100,
			64'd999999999, 64'd1000000000, 64'd4294967295, 64'd4294967296,
			64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
			64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
			64'd9999999999999999999, 64'd10000000000000000000,
			64'd10000000000000000001, 64'd12345678901234567890,
			64'd18446744073709551614, 64'hFFFF_FFFF_FFFF_FFFF
		};
		logic [63:0] num;
		logic [63:0] ten_pow;
		int          pick;
		int          i;
		int          k;

		arst_n       = 1'b0;
		start        = 1'b0;
		value        = 64'd0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		directed_count = directed_values.size();
		foreach (directed_values[j])
			send_value(directed_values[j], 1'b1);

		for (i = 0; i < RANDOM_ITEMS; i++) begin
			pick = $urandom_range(99);
			num  = {$urandom, $urandom};
			if (pick < 40) begin
				// full-width value, usually 19 or 20 digits
			end else if (pick < 65) begin
				num = num >> $urandom_range(63);
			end else if (pick < 80) begin
				// Powers of ten and their neighbors exercise digit-count boundaries.
				ten_pow = 64'd1;
				k       = $urandom_range(19);
				repeat (k) ten_pow = ten_pow * 64'd10;
				num = ten_pow + 64'($urandom_range(2)) - 64'd1;
			end else if (pick < 90) begin
				num = 64'($urandom_range(99));
			end else begin
				num = {64{1'b1}} >> $urandom_range(64);
			end
			send_value(num, !(i >= 120 && i < 180));
		end
		start = 1'b0;

		while (outstanding != 0) @(posedge clk);
		repeat (END_WAIT) @(posedge clk);

		$display("Converted %0d values (%0d directed), %0d digit characters checked.",
			values_taken, directed_count, chars_checked);
		$display("Runs spanned %0d to %0d digits; %0d mismatches.",
			shortest_run, longest_run, mismatches);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
